// ----- design/mag_hard_soft_iron_calibrator_top_macros.svh -----
// Assertion macros shared by the calibrator RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef MAG_HARD_SOFT_IRON_CALIBRATOR_TOP_MACROS_SVH
`define MAG_HARD_SOFT_IRON_CALIBRATOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MHSI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define MHSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mhsi_pkg.sv -----
// Shared types, widths and constants of the magnetometer calibrator.
// Used by mhsi_lane, mhsi_merge and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mhsi_pkg;

   localparam int NUM_AXES       = 3;
   localparam int COUNT_BITS_DEF = 16;

   localparam int SAMPLE_W = 16;
   localparam int HALF_W   = 15;
   localparam int SCALE_W  = 31;
   localparam int MG_W     = 28;
   localparam int HSUM_W   = 17;
   localparam int RES_W    = 19;
   localparam int COEF_W   = 28;
   localparam int ADJ_W    = 8;
   localparam int TOTAL_W  = 16;

   // divider works on hsum << 16, one quotient bit per step
   localparam int NUMER_W   = HSUM_W + 16;
   localparam int DIV_STEPS = NUMER_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   localparam logic [RES_W-1:0]   RES_16BIT_Q16 = 19'd98264;
   localparam logic [RES_W-1:0]   RES_14BIT_Q16 = 19'd393056;
   localparam logic [SCALE_W-1:0] SCALE_SAT     = {SCALE_W{1'b1}};

   localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7FFF;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_TOTAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RES_16BIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADJ_X        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADJ_Y        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADJ_Z        = 3'd4;

   localparam logic [TOTAL_W-1:0] SAMPLE_TOTAL_RESET = 16'd128;
   localparam logic [ADJ_W-1:0]   ADJ_RESET          = 8'd128;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic                       ready_req;
      logic                       overflow;
      logic signed [SAMPLE_W-1:0] sample_x;
      logic signed [SAMPLE_W-1:0] sample_y;
      logic signed [SAMPLE_W-1:0] sample_z;
   } req_type;

   typedef struct packed {
      logic [1:0]                 axis;
      logic signed [SAMPLE_W-1:0] bias_counts;
      logic [HALF_W-1:0]          half_range;
      logic [SCALE_W-1:0]         scale_q16;
      logic                       scale_invalid;
      logic signed [MG_W-1:0]     bias_mg_q8;
      logic                       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LATCH,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } state_type;

   // merge stage to lanes
   typedef struct packed {
      logic update;   // request accepted this cycle
      logic take;     // request carries a usable sample
      logic latch;    // capture run result, clear trackers
      logic prep;     // load divider, form milligauss bias
      logic step;     // advance divider one bit
   } lane_ctrl_type;

   // lane to merge stage
   typedef struct packed {
      logic [HALF_W-1:0]          half;
      logic signed [SAMPLE_W-1:0] bias;
      logic [SCALE_W-1:0]         scale;
      logic                       invalid;
      logic signed [MG_W-1:0]     mg;
   } lane_stat_type;

endpackage

`default_nettype wire

// ----- design/mhsi_lane.sv -----
// One axis lane: held sample, min/max tracker, bias and half-range,
// milligauss bias multiply and a bit-serial scale divider. Uses mhsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhsi_lane (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mhsi_pkg::lane_ctrl_type              ctrl,
   input  wire logic signed [mhsi_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                                 res_16bit,
   input  wire logic [mhsi_pkg::ADJ_W-1:0]           adj,
   input  wire logic [mhsi_pkg::HSUM_W-1:0]          hsum,
   output mhsi_pkg::lane_stat_type                   stat
);
   import mhsi_pkg::*;

   logic signed [SAMPLE_W-1:0] held_ff, held_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] bias_ff, bias_in;
   logic [HALF_W-1:0]          half_ff, half_in;
   logic [COEF_W-1:0]          coef_ff, coef_in;
   logic signed [MG_W-1:0]     mg_ff, mg_in;
   logic [NUMER_W-1:0]         quo_ff, quo_in;
   logic [HSUM_W-1:0]          rem_ff, rem_in;
   logic [HSUM_W-1:0]          dvs_ff, dvs_in;

   logic signed [SAMPLE_W-1:0] cand;
   logic signed [SAMPLE_W:0]   sum;
   logic signed [SAMPLE_W:0]   sum_rnd;
   logic [SAMPLE_W:0]          diff;
   logic [COEF_W-1:0]          res_ext;
   logic [COEF_W-1:0]          adj_ext;
   logic signed [SAMPLE_W+COEF_W:0] prod;
   logic [HSUM_W:0]            trial;
   logic                       fits;

   // pick the sample that feeds the trackers
   always_comb begin
      cand    = (ctrl.take) ? sample : held_ff;
      held_in = (ctrl.update) ? cand : held_ff;
   end

   // track min and max, restart on latch
   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      if (ctrl.latch) begin
         max_in = MAX_RESET;
         min_in = MIN_RESET;
      end else if (ctrl.update) begin
         if (cand > max_ff) max_in = cand;
         if (cand < min_ff) min_in = cand;
      end
   end

   // bias truncates toward zero, half-range of a non-negative span
   always_comb begin
      sum     = {max_ff[SAMPLE_W-1], max_ff} + {min_ff[SAMPLE_W-1], min_ff};
      sum_rnd = sum + (SAMPLE_W+1)'(sum[SAMPLE_W]);
      diff    = {max_ff[SAMPLE_W-1], max_ff} - {min_ff[SAMPLE_W-1], min_ff};
      bias_in = (ctrl.latch) ? sum_rnd[SAMPLE_W:1] : bias_ff;
      half_in = (ctrl.latch) ? diff[HALF_W:1] : half_ff;
   end

   // resolution times sensitivity factor, then bias times that
   always_comb begin
      res_ext = COEF_W'((res_16bit) ? RES_16BIT_Q16 : RES_14BIT_Q16);
      adj_ext = COEF_W'(adj) + COEF_W'(9'd128);
      coef_in = (ctrl.latch) ? res_ext * adj_ext : coef_ff;
      prod    = bias_ff * $signed({1'b0, coef_ff});
      mg_in   = (ctrl.prep) ? prod[MG_W+15:16] : mg_ff;
   end

   // restoring divider: (hsum << 16) / (3 * half)
   always_comb begin
      trial  = {rem_ff, quo_ff[NUMER_W-1]};
      fits   = (trial >= {1'b0, dvs_ff});
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (ctrl.prep) begin
         quo_in = {hsum, 16'd0};
         rem_in = '0;
         dvs_in = {1'b0, half_ff, 1'b0} + HSUM_W'(half_ff);
      end else if (ctrl.step) begin
         quo_in = {quo_ff[NUMER_W-2:0], fits};
         rem_in = (fits) ? HSUM_W'(trial - {1'b0, dvs_ff}) : trial[HSUM_W-1:0];
      end
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         max_ff  <= MAX_RESET;
         min_ff  <= MIN_RESET;
      end else begin
         held_ff <= held_in;
         max_ff  <= max_in;
         min_ff  <= min_in;
      end
   end

   // result datapath
   always_ff @(posedge clock) begin
      bias_ff <= bias_in;
      half_ff <= half_in;
      coef_ff <= coef_in;
      mg_ff   <= mg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   // saturate the scale; zero half-range flags it
   always_comb begin
      stat.half    = half_ff;
      stat.bias    = bias_ff;
      stat.mg      = mg_ff;
      stat.invalid = (half_ff == '0);
      if (half_ff == '0 || quo_ff[NUMER_W-1:SCALE_W] != '0) begin
         stat.scale = SCALE_SAT;
      end else begin
         stat.scale = quo_ff[SCALE_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- design/mhsi_merge.sv -----
// Merge stage: request count, run sequencer, half-range sum for the lane
// dividers and the result register that serializes the three axes. Uses mhsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "mag_hard_soft_iron_calibrator_top_macros.svh"

module mhsi_merge #(
   parameter int COUNT_BITS = mhsi_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           req_valid,
   input  wire logic                                           take,
   output logic                                                req_stall,
   input  wire logic [mhsi_pkg::TOTAL_W-1:0]                   sample_total,
   input  wire mhsi_pkg::lane_stat_type [mhsi_pkg::NUM_AXES-1:0] stat,
   output mhsi_pkg::lane_ctrl_type                             ctrl,
   output logic [mhsi_pkg::HSUM_W-1:0]                         hsum,
   output logic                                                rsp_valid,
   input  wire logic                                           rsp_stall,
   output mhsi_pkg::rsp_type                                   rsp_data
);
   import mhsi_pkg::*;

   localparam int CMP_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0]  cnt_inc;
   logic [TOTAL_W-1:0]     target;
   logic                   run_end;
   logic                   div_done;
   logic                   rsp_take;
   logic                   load;
   logic [1:0]             sel_idx;
   lane_stat_type          sel;

   // count requests, saturating; a run ends at the target or at saturation
   always_comb begin
      cnt_inc = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + COUNT_BITS'(1);
      target  = (sample_total == '0) ? TOTAL_W'(1) : sample_total;
      run_end = (CMP_W'(cnt_inc) >= CMP_W'(target)) || (cnt_inc == CNT_MAX);
      cnt_in  = cnt_ff;
      if (ctrl.update) cnt_in = (run_end) ? '0 : cnt_inc;
   end

   assign div_done = (state_ff == ST_DIV) && (step_ff == STEP_W'(DIV_STEPS - 1));
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid && run_end) state_in = ST_LATCH;
         ST_LATCH: state_in = ST_PREP;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_EMIT;
         ST_EMIT:  if (rsp_take && idx_ff == AXIS_Z) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = 1'b1;
      ctrl.update = 1'b0;
      ctrl.take   = take;
      ctrl.latch  = 1'b0;
      ctrl.prep   = 1'b0;
      ctrl.step   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctrl.update = req_valid;
         end
         ST_LATCH: ctrl.latch = 1'b1;
         ST_PREP:  ctrl.prep  = 1'b1;
         ST_DIV:   ctrl.step  = 1'b1;
         default:  req_stall  = 1'b1;
      endcase
   end

   // sum of half-ranges for every lane divider
   assign hsum = HSUM_W'(stat[0].half) + HSUM_W'(stat[1].half) + HSUM_W'(stat[2].half);

   // divider step count
   always_comb begin
      step_in = step_ff;
      if (ctrl.prep) step_in = '0;
      else if (ctrl.step) step_in = step_ff + STEP_W'(1);
   end

   // pick the lane for the next result; x loads once the divider has finished
   always_comb begin
      load    = (state_ff == ST_EMIT) &&
                (!rsp_valid_ff || (rsp_take && idx_ff != AXIS_Z));
      sel_idx = (rsp_valid_ff) ? idx_ff + 2'd1 : AXIS_X;
      case (sel_idx)
         AXIS_X:  sel = stat[0];
         AXIS_Y:  sel = stat[1];
         default: sel = stat[2];
      endcase
   end

   // result register: load, advance, drop after z
   always_comb begin
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in               = sel_idx;
         rsp_valid_in         = 1'b1;
         rsp_in.axis          = sel_idx;
         rsp_in.bias_counts   = sel.bias;
         rsp_in.half_range    = sel.half;
         rsp_in.scale_q16     = sel.scale;
         rsp_in.scale_invalid = sel.invalid;
         rsp_in.bias_mg_q8    = sel.mg;
         rsp_in.last          = (sel_idx == AXIS_Z);
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         idx_ff       <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MHSI_ASSERT_SAME(a_rsp_in_emit, clock, reset, rsp_valid_ff, state_ff == ST_EMIT, "result outside emit")
   `MHSI_ASSERT_SAME(a_last_on_z, clock, reset, rsp_valid_ff && rsp_ff.last, rsp_ff.axis == AXIS_Z, "last not on z")
   `MHSI_ASSERT_SAME(a_step_range, clock, reset, state_ff == ST_DIV, step_ff < STEP_W'(DIV_STEPS), "divider overran")
   `MHSI_ASSERT_NEXT(a_run_latch, clock, reset, state_ff == ST_IDLE && req_valid && run_end, state_ff == ST_LATCH, "run end missed")

endmodule

`default_nettype wire

// ----- design/mag_hard_soft_iron_calibrator_top.sv -----
// Magnetometer hard/soft-iron calibrator. A request that ends no run is taken without a
// stall and the next may follow at once. The request that ends a run stalls the request
// side through capture, divider load, the 33-step scale divider in each of the three axis
// lanes, run side by side, and loading of the x result, and then while the three results
// are handed out, longer if the result side stalls. Results come in x, y, z order with
// last on z. Configuration writes are taken in any cycle.
// Depends on mhsi_pkg, mhsi_lane and mhsi_merge.
`timescale 1ns / 1ps
`default_nettype none

module mag_hard_soft_iron_calibrator_top #(
   parameter int COUNT_BITS = mhsi_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire mhsi_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output mhsi_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mhsi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mhsi_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mhsi_pkg::*;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               res16_ff, res16_in;
   logic [ADJ_W-1:0]   adj_ff [NUM_AXES];
   logic [ADJ_W-1:0]   adj_in [NUM_AXES];

   logic signed [SAMPLE_W-1:0]          samp [NUM_AXES];
   lane_ctrl_type                       ctrl;
   lane_stat_type [NUM_AXES-1:0]        stat;
   logic [HSUM_W-1:0]                   hsum;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      total_in = total_ff;
      res16_in = res16_ff;
      adj_in   = adj_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_TOTAL: total_in  = csr_wdata[TOTAL_W-1:0];
            CSR_RES_16BIT:    res16_in  = csr_wdata[0];
            CSR_ADJ_X:        adj_in[0] = csr_wdata[ADJ_W-1:0];
            CSR_ADJ_Y:        adj_in[1] = csr_wdata[ADJ_W-1:0];
            CSR_ADJ_Z:        adj_in[2] = csr_wdata[ADJ_W-1:0];
            default:          total_in  = total_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= SAMPLE_TOTAL_RESET;
         res16_ff  <= 1'b1;
         adj_ff[0] <= ADJ_RESET;
         adj_ff[1] <= ADJ_RESET;
         adj_ff[2] <= ADJ_RESET;
      end else begin
         total_ff <= total_in;
         res16_ff <= res16_in;
         adj_ff   <= adj_in;
      end
   end

   // split the request into per-axis samples
   assign samp[0] = req_data.sample_x;
   assign samp[1] = req_data.sample_y;
   assign samp[2] = req_data.sample_z;

   // one lane per axis
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      mhsi_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sample    (samp[g]),
         .res_16bit (res16_ff),
         .adj       (adj_ff[g]),
         .hsum      (hsum),
         .stat      (stat[g])
      );
   end

   mhsi_merge #(
      .COUNT_BITS (COUNT_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .take         (req_data.ready_req && !req_data.overflow),
      .req_stall    (req_stall),
      .sample_total (total_ff),
      .stat         (stat),
      .ctrl         (ctrl),
      .hsum         (hsum),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

// ----- test/mag_hard_soft_iron_calibrator_top_test.sv -----
// Self-checking bench for the magnetometer hard/soft-iron calibrator top level.
// Depends on mhsi_pkg and mag_hard_soft_iron_calibrator_top; predicts every axis result
// from its own min/max tracker and checks it field by field.
`timescale 1ns / 1ps

module mag_hard_soft_iron_calibrator_top_test;
   import mhsi_pkg::*;

   // idle time that covers the run-end work and its three results, with margin
   localparam int SETTLE       = 48;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RUN_CAP      = 65535;
   localparam int DRILL_ROWS   = 21;
   localparam int RAND_PHASES  = 9;
   localparam int PHASE_ITEMS  = 20;
   localparam longint GAIN_16  = 98264;
   localparam longint GAIN_14  = 393056;
   localparam logic [1:0] AXIS_CODE [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

   typedef struct packed {
      logic [15:0]        total;
      req_type            rq;
      logic               typed;
      logic signed [15:0] t_bias;
      logic [14:0]        t_half;
      logic [30:0]        t_scale;
      logic               t_inv;
      logic signed [27:0] t_mg;
   } step_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // tracker copy and register copy
   int          held [3];
   int          peak_hi [3];
   int          peak_lo [3];
   int unsigned run_len;
   int unsigned cfg_total;
   bit          cfg_res16;
   int unsigned cfg_adj [3];

   rsp_type     axis_results_due [$];
   int unsigned cycles = 0;
   int unsigned mismatches = 0;
   int unsigned readings_sent = 0;
   int unsigned runs_checked = 0;
   int unsigned csr_writes = 0;
   int          rsp_hold;
   bit          req_up = 1'b0;
   bit          req_gaps = 1'b1;
   bit          rsp_gaps = 1'b1;
   step_row     drill [DRILL_ROWS];

   mag_hard_soft_iron_calibrator_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycles,
                  axis_results_due.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report(string msg);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH cycle %0d: %s", cycles, msg);
   endtask

   function automatic void clear_trackers();
      for (int i = 0; i < 3; i++) begin
         peak_hi[i] = -32768;
         peak_lo[i] = 32767;
      end
      run_len = 0;
   endfunction

   // Advance the tracker by one read attempt; queue three axis results on a run end.
   function automatic bit track_reading(req_type r);
      int unsigned     goal;
      int              half [3];
      int              bias;
      longint unsigned hsum;
      longint unsigned quo;
      longint          gain;
      longint          mg;
      rsp_type         want;
      if (r.ready_req && !r.overflow) begin
         held[0] = r.sample_x;
         held[1] = r.sample_y;
         held[2] = r.sample_z;
      end
      for (int i = 0; i < 3; i++) begin
         if (held[i] > peak_hi[i]) peak_hi[i] = held[i];
         if (held[i] < peak_lo[i]) peak_lo[i] = held[i];
      end
      if (run_len < RUN_CAP) run_len++;
      goal = (cfg_total == 0) ? 1 : cfg_total;
      if (run_len < goal && run_len < RUN_CAP) return 1'b0;

      for (int i = 0; i < 3; i++)
         half[i] = (peak_hi[i] - peak_lo[i]) / 2;
      hsum = longint'(half[0]) + longint'(half[1]) + longint'(half[2]);
      gain = cfg_res16 ? GAIN_16 : GAIN_14;
      for (int i = 0; i < 3; i++) begin
         bias = (peak_hi[i] + peak_lo[i]) / 2;
         want.axis = AXIS_CODE[i];
         want.bias_counts = bias[15:0];
         want.half_range = half[i][14:0];
         if (half[i] == 0) begin
            want.scale_q16 = 31'h7FFF_FFFF;
            want.scale_invalid = 1'b1;
         end else begin
            quo = (hsum << 16) / (3 * longint'(half[i]));
            if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
            want.scale_q16 = quo[30:0];
            want.scale_invalid = 1'b0;
         end
         // floor of the Q16 product
         mg = (longint'(bias) * gain * longint'(cfg_adj[i] + 128)) >>> 16;
         want.bias_mg_q8 = mg[27:0];
         want.last = (AXIS_CODE[i] == AXIS_Z);
         axis_results_due.push_back(want);
      end
      clear_trackers();
      return 1'b1;
   endfunction

   // Compare one accepted result with the oldest one due.
   task automatic check_axis(rsp_type got);
      rsp_type want;
      if (axis_results_due.size() == 0) begin
         report($sformatf("result for axis %0d with none due", got.axis));
      end else begin
         want = axis_results_due.pop_front();
         if (got.axis !== want.axis)
            report($sformatf("axis got %0d want %0d", got.axis, want.axis));
         if (got.bias_counts !== want.bias_counts)
            report($sformatf("axis %0d bias_counts got %0d want %0d", want.axis,
                             got.bias_counts, want.bias_counts));
         if (got.half_range !== want.half_range)
            report($sformatf("axis %0d half_range got %0d want %0d", want.axis,
                             got.half_range, want.half_range));
         if (got.scale_q16 !== want.scale_q16)
            report($sformatf("axis %0d scale_q16 got %0d want %0d", want.axis,
                             got.scale_q16, want.scale_q16));
         if (got.scale_invalid !== want.scale_invalid)
            report($sformatf("axis %0d scale_invalid got %b want %b", want.axis,
                             got.scale_invalid, want.scale_invalid));
         if (got.bias_mg_q8 !== want.bias_mg_q8)
            report($sformatf("axis %0d bias_mg_q8 got %0d want %0d", want.axis,
                             got.bias_mg_q8, want.bias_mg_q8));
         if (got.last !== want.last)
            report($sformatf("axis %0d last got %b want %b", want.axis, got.last,
                             want.last));
         if (want.last) runs_checked++;
      end
   endtask

   // Result side: check on accept, then hold stall for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_axis(rsp_data);
            rsp_hold = rsp_gaps ? $urandom_range(0, 8) : 0;
         end
         rsp_stall <= (rsp_hold != 0);
         if (rsp_hold != 0) rsp_hold--;
      end
   end

   // Drop valid and wait for every due result.
   task automatic drain_all();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      do @(posedge clock); while (axis_results_due.size() != 0);
   endtask

   // Offer one request after a drawn gap and hold it until accepted.
   task automatic send_reading(req_type r, output bit closed);
      int gap;
      gap = req_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         if (req_up) begin
            req_valid <= 1'b0;
            req_up = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      req_up = 1'b1;
      do @(posedge clock); while (req_stall);
      closed = track_reading(r);
      readings_sent++;
   endtask

   // Idle the block, then write the registers that change (or all of them).
   task automatic apply_settings(int unsigned total, bit res16, int unsigned ax,
                                 int unsigned ay, int unsigned az, bit every);
      logic [CSR_IDX_W-1:0] idx [5];
      logic [15:0]          val [5];
      logic [15:0]          now [5];
      bit                   wrote;
      idx = '{CSR_SAMPLE_TOTAL, CSR_RES_16BIT, CSR_ADJ_X, CSR_ADJ_Y, CSR_ADJ_Z};
      val = '{total[15:0], {15'd0, res16}, ax[15:0], ay[15:0], az[15:0]};
      now = '{cfg_total[15:0], {15'd0, cfg_res16}, cfg_adj[0][15:0], cfg_adj[1][15:0],
              cfg_adj[2][15:0]};
      wrote = 1'b0;
      drain_all();
      repeat (SETTLE) @(posedge clock);
      for (int k = 0; k < 5; k++) begin
         if (every || val[k] != now[k]) begin
            csr_valid <= 1'b1;
            csr_index <= idx[k];
            csr_wdata <= val[k];
            do @(posedge clock); while (!csr_ready);
            wrote = 1'b1;
            csr_writes++;
         end
      end
      if (wrote) csr_valid <= 1'b0;
      cfg_total = val[0];
      cfg_res16 = val[1][0];
      cfg_adj[0] = val[2];
      cfg_adj[1] = val[3];
      cfg_adj[2] = val[4];
   endtask

   function automatic step_row row(int total, bit rdy, bit ovf, int x, int y, int z,
                                   bit typed = 1'b0, int bias = 0, int half = 0,
                                   logic [30:0] scale = '0, bit inv = 1'b0, int mg = 0);
      step_row s;
      s.total = total[15:0];
      s.rq.ready_req = rdy;
      s.rq.overflow = ovf;
      s.rq.sample_x = x[15:0];
      s.rq.sample_y = y[15:0];
      s.rq.sample_z = z[15:0];
      s.typed = typed;
      s.t_bias = bias[15:0];
      s.t_half = half[14:0];
      s.t_scale = scale;
      s.t_inv = inv;
      s.t_mg = mg[27:0];
      return s;
   endfunction

   function automatic req_type random_reading();
      req_type r;
      int      s [3];
      for (int a = 0; a < 3; a++) begin
         case ($urandom_range(0, 5))
            0: s[a] = -32768;
            1: s[a] = 32767;
            2, 3: s[a] = int'($urandom_range(0, 600)) - 300;
            default: s[a] = $urandom;
         endcase
      end
      // mostly usable samples, the rest with random ready and overflow flags
      if ($urandom_range(0, 3) != 0) begin
         r.ready_req = 1'b1;
         r.overflow = 1'b0;
      end else begin
         r.ready_req = $urandom_range(0, 1);
         r.overflow = $urandom_range(0, 1);
      end
      r.sample_x = s[0][15:0];
      r.sample_y = s[1][15:0];
      r.sample_z = s[2][15:0];
      return r;
   endfunction

   function automatic int unsigned pick_adj();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   initial begin
      bit          closed;
      int          n;
      int          sel;
      int unsigned total;
      int          pause_at;

      // reset state of the copy
      for (int i = 0; i < 3; i++) begin
         held[i] = 0;
         cfg_adj[i] = 128;
      end
      cfg_total = 128;
      cfg_res16 = 1'b1;
      clear_trackers();

      // directed rows: reset held sample, reuse paths, extremes, zero total,
      // truncation of odd sums, held sample across runs, zero half-range per axis
      drill = '{
         row(1, 0, 0, 'h1234, 'h1234, 'h1234, 1, 0, 0, SCALE_SAT, 1, 0),
         row(1, 1, 1, -5, -5, -5, 1, 0, 0, SCALE_SAT, 1, 0),
         row(1, 1, 0, 32767, 32767, 32767, 1, 32767, 0, SCALE_SAT, 1, 12577408),
         row(1, 0, 1, 0, 0, 0, 1, 32767, 0, SCALE_SAT, 1, 12577408),
         row(1, 1, 0, -32768, -32768, -32768, 1, -32768, 0, SCALE_SAT, 1, -12577792),
         row(1, 0, 0, 1, 1, 1, 1, -32768, 0, SCALE_SAT, 1, -12577792),
         row(1, 1, 0, 100, -200, 0),
         row(1, 1, 0, -1, 1, -7),
         row(0, 1, 0, 5, 6, 7),
         row(0, 0, 1, 3, 4, 5),
         row(2, 1, 0, 32767, 32767, 32767),
         row(2, 1, 0, -32768, -32768, -32768, 1, 0, 32767, 31'd65536, 0, 0),
         row(2, 1, 0, -3, -3, -3),
         row(2, 1, 0, -4, 9, 0),
         row(2, 1, 1, 111, 222, 333),
         row(2, 0, 0, 0, 0, 0),
         row(3, 1, 0, 50, -100, 7),
         row(3, 1, 0, 50, 100, -9),
         row(3, 1, 0, 50, 0, 30),
         row(2, 1, 0, 21845, -21846, 1),
         row(2, 1, 0, -21846, 21845, -1)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table; typed rows override the predicted axis values
      for (int k = 0; k < DRILL_ROWS; k++) begin
         if (drill[k].total != cfg_total)
            apply_settings(drill[k].total, cfg_res16, cfg_adj[0], cfg_adj[1], cfg_adj[2],
                           1'b0);
         send_reading(drill[k].rq, closed);
         if (closed && drill[k].typed) begin
            for (int a = 0; a < 3; a++) begin
               n = axis_results_due.size() - 3 + a;
               axis_results_due[n].bias_counts = drill[k].t_bias;
               axis_results_due[n].half_range = drill[k].t_half;
               axis_results_due[n].scale_q16 = drill[k].t_scale;
               axis_results_due[n].scale_invalid = drill[k].t_inv;
               axis_results_due[n].bias_mg_q8 = drill[k].t_mg;
            end
         end
      end

      // longest run setting, then cut it short with a small total
      apply_settings(65535, 1'b0, 0, 255, 128, 1'b1);
      for (int j = 0; j < 18; j++) send_reading(random_reading(), closed);
      apply_settings(2, 1'b0, 0, 255, 128, 1'b0);
      for (int j = 0; j < 5; j++) send_reading(random_reading(), closed);

      // random phases with fresh settings and idling modes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) total = 0;
         else if (sel <= 2) total = $urandom_range(5, 24);
         else total = $urandom_range(1, 4);
         apply_settings(total, $urandom_range(0, 1), pick_adj(), pick_adj(), pick_adj(),
                        ph == 0);
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         pause_at = $urandom_range(0, PHASE_ITEMS - 1);
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            if (j == pause_at) drain_all();
            send_reading(random_reading(), closed);
         end
      end

      drain_all();
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d magnetometer read attempts over %0d register writes;", readings_sent,
               csr_writes);
      $display("checked %0d calibration runs of three axis results each.", runs_checked);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
